// ----- design/cds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_pkg: shared constants for the clock divider select unit
// Default widths, the divider limit write width, and the reset values of the divider limit and latched divider.
// ----------------------------------------------------------------------------
package cds_pkg;

  // default field widths
  localparam int unsigned FREQ_WIDTH_DEF = 32;
  localparam int unsigned DIV_WIDTH_DEF  = 16;

  // width of the divider limit write beat
  localparam int unsigned CFG_WIDTH = 16;

  // reset values
  localparam int unsigned MAX_DIV_RESET  = 16;
  localparam int unsigned PROG_DIV_RESET = 1;

endpackage : cds_pkg
`default_nettype wire

// ----- design/cds_div_pipe.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_div_pipe: pipelined restoring divider
// One quotient bit per stage, DW stages, a new operand pair every cycle
// while en is high. Division by zero gives an all-ones quotient.
// ----------------------------------------------------------------------------
module cds_div_pipe #(
  parameter int unsigned DW = 32,
  parameter int unsigned VW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] dvd_i,
  input  wire logic [VW-1:0] dsr_i,
  output logic      [DW-1:0] quo_o
);

  logic [VW-1:0] rem_r [DW];
  logic [DW-1:0] quo_r [DW];
  logic [DW-1:0] dvd_r [DW];
  logic [VW-1:0] dsr_r [DW];

  genvar s;
  generate
    for (s = 0; s < DW; s++) begin : g_stage
      logic [VW-1:0] rem_in;
      logic [DW-1:0] quo_in;
      logic [DW-1:0] dvd_in;
      logic [VW-1:0] dsr_in;
      logic [VW:0]   trial;
      logic [VW:0]   diff;
      logic          ge;

      // stage inputs
      if (s == 0) begin : g_first
        assign rem_in = '0;
        assign quo_in = '0;
        assign dvd_in = dvd_i;
        assign dsr_in = dsr_i;
      end else begin : g_next
        assign rem_in = rem_r[s-1];
        assign quo_in = quo_r[s-1];
        assign dvd_in = dvd_r[s-1];
        assign dsr_in = dsr_r[s-1];
      end

      // trial subtract for this quotient bit
      assign trial = {rem_in, dvd_in[DW-1-s]};
      assign diff  = trial - {1'b0, dsr_in};
      assign ge    = (trial >= {1'b0, dsr_in});

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= ge ? diff[VW-1:0] : trial[VW-1:0];
          if (DW > 1) begin
            quo_r[s] <= {quo_in[DW-2:0], ge};
          end else begin
            quo_r[s] <= DW'(ge);
          end
          dvd_r[s] <= dvd_in;
          dsr_r[s] <= dsr_in;
        end
      end
    end
  endgenerate

  assign quo_o = quo_r[DW-1];

endmodule : cds_div_pipe
`default_nettype wire

// ----- design/clock_divider_select_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// path from input beat to result beat: first divider, clamp stage, second dividers, check stage, select stage
// throughput: one beat per cycle; the whole pipe holds while a result waits unaccepted
// the depth is set by two bit-per-stage restoring dividers in series
// reset: synchronous active low; clears valid bits, divider limit to 16,
// latched divider to 1
// ----------------------------------------------------------------------------
// clock_divider_select_unit: integer clock divider selection
// Picks, of the two dividers around parent/target, the one closest to the target that passes
// its window bound (lower: max_freq, higher: min_freq), and latches it unless the request is a query.
// ----------------------------------------------------------------------------
module clock_divider_select_unit
  import cds_pkg::*;
#(
  parameter int unsigned FREQ_WIDTH = FREQ_WIDTH_DEF,
  parameter int unsigned DIV_WIDTH  = DIV_WIDTH_DEF,
  localparam int unsigned IN_W  = ((4 * FREQ_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((FREQ_WIDTH + DIV_WIDTH + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // divider limit register
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_WIDTH-1:0] cfg_data,
  // request beats
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,  // parent_freq, target_freq, min_freq, max_freq
  input  wire logic                 in_tuser,  // query_only
  // result beats
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [OUT_W-1:0]          out_tdata, // chosen_divider, output_freq
  output logic                      out_tuser  // found
);

  localparam int unsigned F  = FREQ_WIDTH;
  localparam int unsigned D  = DIV_WIDTH;
  localparam int unsigned CW = (F > D) ? F : D;

  typedef struct packed {
    logic [F-1:0] parent;
    logic [F-1:0] target;
    logic [F-1:0] fmin;
    logic [F-1:0] fmax;
    logic         query;
  } req_t;

  typedef struct packed {
    logic [F-1:0] target;
    logic [F-1:0] fmin;
    logic [F-1:0] fmax;
    logic         query;
    logic [D-1:0] lo;
    logic [D:0]   hi;
    logic         lo_nz;
    logic         hi_in;
  } cand_t;

  logic         adv;
  logic [D-1:0] max_div_r;
  logic [D-1:0] prog_div_r;
  logic [D-1:0] lim;

  // pipe advances unless a result is stuck at the output
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;

  // divider limit register
  logic [D-1:0] cfg_val;
  generate
    if (D >= CFG_WIDTH) begin : g_cfg_wide
      assign cfg_val = D'(cfg_data);
    end else begin : g_cfg_narrow
      assign cfg_val = cfg_data[D-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_div_r <= D'(MAX_DIV_RESET);
    end else if (cfg_valid && cfg_ready) begin
      max_div_r <= cfg_val;
    end
  end

  assign lim = (max_div_r != '0) ? (max_div_r - 1'b1) : '0;

  // request unpack
  req_t req_in;
  assign req_in.parent = in_tdata[F-1:0];
  assign req_in.target = in_tdata[2*F-1:F];
  assign req_in.fmin   = in_tdata[3*F-1:2*F];
  assign req_in.fmax   = in_tdata[4*F-1:3*F];
  assign req_in.query  = in_tuser;

  // first divider: parent / target
  logic [F-1:0] q1;
  cds_div_pipe #(.DW(F), .VW(F)) u_div_q (
    .clk   (clk),
    .en    (adv),
    .dvd_i (req_in.parent),
    .dsr_i (req_in.target),
    .quo_o (q1)
  );

  req_t req1_r [F];
  logic v1_r   [F];

  genvar i;
  generate
    for (i = 0; i < F; i++) begin : g_side1
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v1_r[i] <= 1'b0;
        end else if (adv) begin
          v1_r[i] <= (i == 0) ? (in_tvalid && in_tready) : v1_r[(i == 0) ? 0 : i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          req1_r[i] <= (i == 0) ? req_in : req1_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  endgenerate

  // clamp stage: lower and higher candidates
  req_t         rq;
  logic [D-1:0] lo_nxt;
  logic [D:0]   hi_nxt;
  cand_t        cand_r;
  logic [F-1:0] parent_c_r;
  logic         vc_r;

  assign rq     = req1_r[F-1];
  assign lo_nxt = (CW'(q1) > CW'(lim)) ? lim : D'(q1);
  assign hi_nxt = {1'b0, lo_nxt} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= v1_r[F-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cand_r.target <= rq.target;
      cand_r.fmin   <= rq.fmin;
      cand_r.fmax   <= rq.fmax;
      cand_r.query  <= rq.query;
      cand_r.lo     <= lo_nxt;
      cand_r.hi     <= hi_nxt;
      cand_r.lo_nz  <= (lo_nxt != '0);
      cand_r.hi_in  <= (hi_nxt <= {1'b0, max_div_r});
      parent_c_r    <= rq.parent;
    end
  end

  // second dividers: parent / lo and parent / hi
  logic [F-1:0] lo_hz;
  logic [F-1:0] hi_hz;

  cds_div_pipe #(.DW(F), .VW(D+1)) u_div_lo (
    .clk   (clk),
    .en    (adv),
    .dvd_i (parent_c_r),
    .dsr_i ({1'b0, cand_r.lo}),
    .quo_o (lo_hz)
  );

  cds_div_pipe #(.DW(F), .VW(D+1)) u_div_hi (
    .clk   (clk),
    .en    (adv),
    .dvd_i (parent_c_r),
    .dsr_i (cand_r.hi),
    .quo_o (hi_hz)
  );

  cand_t cand2_r [F];
  logic  v2_r    [F];

  generate
    for (i = 0; i < F; i++) begin : g_side2
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v2_r[i] <= 1'b0;
        end else if (adv) begin
          v2_r[i] <= (i == 0) ? vc_r : v2_r[(i == 0) ? 0 : i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (adv) begin
          cand2_r[i] <= (i == 0) ? cand_r : cand2_r[(i == 0) ? 0 : i-1];
        end
      end
    end
  endgenerate

  // check stage: window tests and distances to the target
  cand_t        ck;
  logic         vx_r;
  logic         lo_ok_r, hi_ok_r, query_x_r;
  logic [F-1:0] dlo_r, dhi_r, lo_hz_r, hi_hz_r;
  logic [D-1:0] lo_x_r, hi_x_r;

  assign ck = cand2_r[F-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vx_r <= 1'b0;
    end else if (adv) begin
      vx_r <= v2_r[F-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lo_ok_r   <= ck.lo_nz && (lo_hz <= ck.fmax);
      hi_ok_r   <= ck.hi_in && (hi_hz >= ck.fmin);
      dlo_r     <= (lo_hz > ck.target) ? (lo_hz - ck.target) : (ck.target - lo_hz);
      dhi_r     <= (hi_hz > ck.target) ? (hi_hz - ck.target) : (ck.target - hi_hz);
      lo_hz_r   <= lo_hz;
      hi_hz_r   <= hi_hz;
      lo_x_r    <= ck.lo;
      hi_x_r    <= ck.hi[D-1:0];
      query_x_r <= ck.query;
    end
  end

  // select stage: closer candidate wins, tie to the lower divider
  logic         take_hi;
  logic         found_nxt;
  logic [D-1:0] div_nxt;
  logic [F-1:0] hz_nxt;
  logic         found_r;
  logic [D-1:0] div_r;
  logic [F-1:0] hz_r;
  logic         out_valid_r;

  assign take_hi   = hi_ok_r && (!lo_ok_r || (dhi_r < dlo_r));
  assign found_nxt = lo_ok_r || hi_ok_r;
  assign div_nxt   = take_hi ? hi_x_r : (lo_ok_r ? lo_x_r : '0);
  assign hz_nxt    = take_hi ? hi_hz_r : (lo_ok_r ? lo_hz_r : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      prog_div_r  <= D'(PROG_DIV_RESET);
    end else if (adv) begin
      out_valid_r <= vx_r;
      if (vx_r && found_nxt && !query_x_r) begin
        prog_div_r <= div_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      found_r <= found_nxt;
      div_r   <= div_nxt;
      hz_r    <= hz_nxt;
    end
  end

  // result pack; the latched divider is not visible at the ports and is only reduced into prog_unused
  logic prog_unused;
  assign prog_unused = ^prog_div_r;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = found_r;
  assign out_tdata  = OUT_W'({hz_r, div_r});

endmodule : clock_divider_select_unit
`default_nettype wire

// ----- design/cds_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cds_checker: port level checks for the clock divider select unit
// Watches the result beats and the stall behavior at the top level ports.
// ----------------------------------------------------------------------------
module cds_checker
  import cds_pkg::*;
#(
  parameter int unsigned FREQ_WIDTH = FREQ_WIDTH_DEF,
  parameter int unsigned DIV_WIDTH  = DIV_WIDTH_DEF,
  localparam int unsigned OUT_W = ((FREQ_WIDTH + DIV_WIDTH + 7) / 8) * 8
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata,
  input wire logic             out_tuser
);

  // a stalled result beat holds its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // no acceptable divider means an all-zero payload
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("payload not zero without a found divider");

  // a found divider is never zero
  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[DIV_WIDTH-1:0] != '0)
    else $error("found with a zero divider");

  // input side only waits behind a stalled result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without output back pressure");

endmodule : cds_checker

bind clock_divider_select_unit cds_checker #(
  .FREQ_WIDTH (FREQ_WIDTH),
  .DIV_WIDTH  (DIV_WIDTH)
) u_cds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
